[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/pcf_pkg.sv]
`timescale 1ns / 1ps
package pcf_pkg;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 17;
  localparam int GRID      = 5;
  localparam int GRID_HALF = 2;

  localparam int LUMA_MIN   = 16;
  localparam int LUMA_MAX   = 240;
  localparam int CHROMA_MIN = -112;
  localparam int CHROMA_MAX = 112;
  localparam int CHROMA_OFS = 128;

  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] dmag;
  } div_t;

  typedef enum logic [2:0] {
    CFG_COEFF_A   = 3'd0,
    CFG_COEFF_B   = 3'd1,
    CFG_COEFF_C   = 3'd2,
    CFG_COEFF_FIN = 3'd3,
    CFG_DIVISOR   = 3'd4,
    CFG_WIDTH     = 3'd5,
    CFG_HEIGHT    = 3'd6,
    CFG_CHROMA    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WMUL, S_WMOD, S_WRITE, S_NMUL, S_OMUL, S_CMP, S_OMOD,
    S_BASE, S_TAP, S_DRAIN, S_DLOAD, S_DIV, S_FIN
  } state_t;

endpackage

[rtl/pcf_div_cell.sv]
`timescale 1ns / 1ps
module pcf_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  pcf_pkg::div_t d_in,
  output pcf_pkg::div_t d_out
);

  logic [pcf_pkg::DIV_DEN_W:0]   trial;
  logic                          ge;
  logic [pcf_pkg::DIV_DEN_W:0]   diff;

  always_comb begin
    trial = {d_in.rem, d_in.num[pcf_pkg::DIV_NUM_W-1]};
    ge    = trial >= {1'b0, d_in.dmag};
    diff  = trial - {1'b0, d_in.dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else begin
      d_out.valid <= d_in.valid;
    end
    d_out.neg  <= d_in.neg;
    d_out.dmag <= d_in.dmag;
    d_out.rem  <= ge ? diff[pcf_pkg::DIV_DEN_W-1:0] : trial[pcf_pkg::DIV_DEN_W-1:0];
    d_out.num  <= {d_in.num[pcf_pkg::DIV_NUM_W-2:0], 1'b0};
    d_out.quo  <= {d_in.quo[pcf_pkg::DIV_NUM_W-2:0], ge};
  end

endmodule

[rtl/pcf_div_chain.sv]
`timescale 1ns / 1ps
module pcf_div_chain (
  input  logic          clk,
  input  logic          rst,
  input  pcf_pkg::div_t d_in,
  output pcf_pkg::div_t d_out
);

  pcf_pkg::div_t link [0:pcf_pkg::DIV_NUM_W];

  assign link[0] = d_in;

  // One quotient bit per cell, most significant first.
  for (genvar i = 0; i < pcf_pkg::DIV_NUM_W; i++) begin : g_cell
    pcf_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .d_in  (link[i]),
      .d_out (link[i+1])
    );
  end

  assign d_out = link[pcf_pkg::DIV_NUM_W];

endmodule

[rtl/plane_convolution_filter.sv]
`timescale 1ns / 1ps
// A pixel with no result due passes IDLE, WMUL, one line-store modulo pass (WMOD), WRITE, NMUL,
// OMUL and CMP before the next input is taken; a flush with no result due skips WMOD and WRITE.
// An item that yields a result loads its output beat after OMOD (a second modulo pass for a pixel),
// BASE, 25 tap reads on the line-store read port, DRAIN, DLOAD, the 24 divider cells and FIN.
// One item is in flight at a time; a finished beat may wait on the output while the next is taken.
// Reset (synchronous) clears counters and restores register defaults; the line store is not cleared.
module plane_convolution_filter #(
  parameter int MAX_WIDTH   = 2048,
  parameter int KERNEL_SIZE = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int HALF = KERNEL_SIZE / 2;
  localparam int CH   = (HALF < pcf_pkg::GRID_HALF) ? HALF : pcf_pkg::GRID_HALF;
  localparam int NT   = 2 * CH + 1;
  localparam int TW   = $clog2(NT + 1);
  localparam int L    = (2 * HALF + 1) * (MAX_WIDTH + 1);
  localparam int AW   = $clog2(L);
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = 13;
  localparam int QW   = RW + CW + 1;
  localparam int MI   = QW - AW;
  localparam int KW   = $clog2(MI + 1);
  localparam logic [QW-1:0] LQ = QW'(L);

  // configuration
  logic [63:0] coef_a, coef_b, coef_c;
  logic [7:0]  coef_f;
  logic [16:0] divisor;
  logic [11:0] plane_width;
  logic [12:0] plane_height;
  logic        chroma_mode;

  // control
  pcf_pkg::state_t state, state_next;
  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row, out_row;
  logic          op_flush;
  logic [7:0]    pix;
  logic [QW-1:0] rm, n_val, o_val;
  logic [KW-1:0] mod_k;
  logic [AW-1:0] addr;
  logic [TW-1:0] ty, tx;

  // tap pipeline and accumulator
  logic [7:0]        mem [0:L-1];
  logic [7:0]        rd_data;
  logic              tap_v, tap_ok;
  logic signed [7:0] tap_k;
  logic signed [23:0] acc;

  pcf_pkg::div_t div_in, div_out;
  logic [pcf_pkg::DIV_NUM_W-1:0] q_quo;
  logic q_nz, q_neg;

  // derived sizes
  logic [CW-1:0] w;
  logic [RW-1:0] ht;
  logic          complete, emit, last_tap, fin_go, mod_ge;
  logic [QW-1:0] q_in, o_in, n_in, mod_sub;
  logic [QW:0]   due;
  logic [AW+1:0] step_v, base_v;
  logic [AW-1:0] step_n, base_n;
  logic [RW+1:0] r_sum;
  logic [CW+1:0] c_sum;
  logic          tap_in;
  logic [4:0]    ki;
  logic [199:0]  coef_all;
  logic signed [8:0]  samp;
  logic signed [16:0] prod;
  logic signed [16:0] d_s;
  logic signed [25:0] qs;
  logic [7:0]    res;
  logic [CW-1:0] oc_inc;
  logic [RW-1:0] or_inc;
  logic          oc_wrap, is_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a       <= '0;
      coef_b       <= '0;
      coef_c       <= '0;
      coef_f       <= '0;
      divisor      <= 17'd1;
      plane_width  <= 12'd720;
      plane_height <= 13'd576;
      chroma_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (pcf_pkg::cfg_idx_t'(cfg_index))
        pcf_pkg::CFG_COEFF_A:   coef_a       <= cfg_data;
        pcf_pkg::CFG_COEFF_B:   coef_b       <= cfg_data;
        pcf_pkg::CFG_COEFF_C:   coef_c       <= cfg_data;
        pcf_pkg::CFG_COEFF_FIN: coef_f       <= cfg_data[7:0];
        pcf_pkg::CFG_DIVISOR:   divisor      <= cfg_data[16:0];
        pcf_pkg::CFG_WIDTH:     plane_width  <= cfg_data[11:0];
        pcf_pkg::CFG_HEIGHT:    plane_height <= cfg_data[12:0];
        pcf_pkg::CFG_CHROMA:    chroma_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (plane_width == '0) begin
      w = CW'(1);
    end else if (32'(plane_width) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(plane_width);
    end
    ht       = (plane_height == '0) ? RW'(1) : plane_height;
    complete = in_row >= ht;
    q_in     = QW'(in_row) * QW'(w) + QW'(in_col);
    n_in     = complete ? QW'(ht) * QW'(w) : q_in;
    o_in     = QW'(out_row) * QW'(w) + QW'(out_col);
    due      = {1'b0, o_val} + (QW+1)'(HALF) * (QW+1)'(w) + (QW+1)'(HALF + 1);
    emit     = complete || ({1'b0, n_val} >= due);
    mod_sub  = LQ << mod_k;
    mod_ge   = rm >= mod_sub;
    // line-store address walk, kept in 0..L-1
    if (tx == TW'(NT - 1)) begin
      step_v = (AW+2)'(addr) + (AW+2)'(w) - (AW+2)'(2 * CH);
    end else begin
      step_v = (AW+2)'(addr) + (AW+2)'(1);
    end
    if (step_v[AW+1]) begin
      step_n = AW'(step_v + (AW+2)'(L));
    end else if (step_v >= (AW+2)'(L)) begin
      step_n = AW'(step_v - (AW+2)'(L));
    end else begin
      step_n = AW'(step_v);
    end
    base_v = (AW+2)'(rm[AW-1:0]) - (AW+2)'(CH) * (AW+2)'(w) - (AW+2)'(CH);
    base_n = base_v[AW+1] ? AW'(base_v + (AW+2)'(L)) : AW'(base_v);
    last_tap = (tx == TW'(NT - 1)) && (ty == TW'(NT - 1));
    r_sum  = (RW+2)'(out_row) + (RW+2)'(ty);
    c_sum  = (CW+2)'(out_col) + (CW+2)'(tx);
    tap_in = (r_sum >= (RW+2)'(CH)) && (r_sum < (RW+2)'(ht) + (RW+2)'(CH)) &&
             (c_sum >= (CW+2)'(CH)) && (c_sum < (CW+2)'(w) + (CW+2)'(CH));
    ki       = 5'((32'(ty) + pcf_pkg::GRID_HALF - CH) * pcf_pkg::GRID +
                  32'(tx) + pcf_pkg::GRID_HALF - CH);
    coef_all = {coef_f, coef_c, coef_b, coef_a};
    samp     = chroma_mode ? ($signed({1'b0, rd_data}) - 9'sd128) : $signed({1'b0, rd_data});
    prod     = samp * tap_k;
    d_s      = (divisor == '0) ? 17'sd1 : $signed(divisor);
    // floor quotient from magnitude quotient
    qs = q_neg ? -($signed({2'b00, q_quo}) + 26'(q_nz)) : $signed({2'b00, q_quo});
    if (chroma_mode) begin
      if (qs < 26'(pcf_pkg::CHROMA_MIN)) begin
        res = 8'(pcf_pkg::CHROMA_MIN + pcf_pkg::CHROMA_OFS);
      end else if (qs > 26'(pcf_pkg::CHROMA_MAX)) begin
        res = 8'(pcf_pkg::CHROMA_MAX + pcf_pkg::CHROMA_OFS);
      end else begin
        res = 8'(qs + 26'(pcf_pkg::CHROMA_OFS));
      end
    end else begin
      if (qs < 26'(pcf_pkg::LUMA_MIN)) begin
        res = 8'(pcf_pkg::LUMA_MIN);
      end else if (qs > 26'(pcf_pkg::LUMA_MAX)) begin
        res = 8'(pcf_pkg::LUMA_MAX);
      end else begin
        res = qs[7:0];
      end
    end
    oc_inc  = out_col + CW'(1);
    oc_wrap = oc_inc >= w;
    or_inc  = out_row + RW'(1);
    is_last = oc_wrap && (or_inc >= ht);
  end

  always_comb begin
    div_in.valid = (state == pcf_pkg::S_DLOAD);
    div_in.neg   = acc[23] ^ d_s[16];
    div_in.rem   = '0;
    div_in.num   = acc[23] ? 24'(-acc) : 24'(acc);
    div_in.quo   = '0;
    div_in.dmag  = d_s[16] ? 17'(-d_s) : 17'(d_s);
  end

  pcf_div_chain u_div (
    .clk   (clk),
    .rst   (rst),
    .d_in  (div_in),
    .d_out (div_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    fin_go        = 1'b0;
    case (state)
      pcf_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = pcf_pkg::S_WMUL;
      end
      pcf_pkg::S_WMUL: begin
        state_next = (!op_flush && !complete) ? pcf_pkg::S_WMOD : pcf_pkg::S_NMUL;
      end
      pcf_pkg::S_WMOD:  if (mod_k == '0) state_next = pcf_pkg::S_WRITE;
      pcf_pkg::S_WRITE: state_next = pcf_pkg::S_NMUL;
      pcf_pkg::S_NMUL:  state_next = pcf_pkg::S_OMUL;
      pcf_pkg::S_OMUL:  state_next = pcf_pkg::S_CMP;
      pcf_pkg::S_CMP:   state_next = emit ? pcf_pkg::S_OMOD : pcf_pkg::S_IDLE;
      pcf_pkg::S_OMOD:  if (mod_k == '0) state_next = pcf_pkg::S_BASE;
      pcf_pkg::S_BASE:  state_next = pcf_pkg::S_TAP;
      pcf_pkg::S_TAP:   if (last_tap) state_next = pcf_pkg::S_DRAIN;
      pcf_pkg::S_DRAIN: state_next = pcf_pkg::S_DLOAD;
      pcf_pkg::S_DLOAD: state_next = pcf_pkg::S_DIV;
      pcf_pkg::S_DIV:   if (div_out.valid) state_next = pcf_pkg::S_FIN;
      pcf_pkg::S_FIN: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          fin_go     = 1'b1;
          state_next = pcf_pkg::S_IDLE;
        end
      end
      default: state_next = pcf_pkg::S_IDLE;
    endcase
  end

  // counters and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (fin_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == pcf_pkg::S_IDLE && s_axis_tvalid && out_row >= ht) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end
      if (state == pcf_pkg::S_WRITE) begin
        if (in_col + CW'(1) >= w) begin
          in_col <= '0;
          in_row <= in_row + RW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (fin_go) begin
        if (is_last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (oc_wrap) begin
          out_col <= '0;
          out_row <= or_inc;
        end else begin
          out_col <= oc_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcf_pkg::S_IDLE && s_axis_tvalid) begin
      op_flush <= s_axis_tuser;
      pix      <= s_axis_tdata;
    end
    if (fin_go) begin
      m_axis_tdata <= res;
      m_axis_tlast <= is_last;
    end
    case (state)
      pcf_pkg::S_WMUL: begin
        rm    <= q_in;
        mod_k <= KW'(MI);
      end
      pcf_pkg::S_NMUL: n_val <= n_in;
      pcf_pkg::S_OMUL: begin
        o_val <= o_in;
        rm    <= o_in;
        mod_k <= KW'(MI);
      end
      pcf_pkg::S_WMOD, pcf_pkg::S_OMOD: begin
        // subtract one shifted copy of the depth per cycle, where it fits
        if (mod_ge) rm <= rm - mod_sub;
        if (mod_k != '0) mod_k <= mod_k - KW'(1);
      end
      pcf_pkg::S_BASE: begin
        addr <= base_n;
        ty   <= '0;
        tx   <= '0;
      end
      pcf_pkg::S_TAP: begin
        addr <= step_n;
        if (tx == TW'(NT - 1)) begin
          tx <= '0;
          ty <= ty + TW'(1);
        end else begin
          tx <= tx + TW'(1);
        end
      end
      pcf_pkg::S_DIV: begin
        if (div_out.valid) begin
          q_quo <= div_out.quo;
          q_nz  <= div_out.rem != '0;
          q_neg <= div_out.neg;
        end
      end
      default: ;
    endcase
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == pcf_pkg::S_WRITE) mem[rm[AW-1:0]] <= pix;
    if (state == pcf_pkg::S_TAP) rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_v <= 1'b0;
    end else begin
      tap_v <= (state == pcf_pkg::S_TAP);
    end
    tap_ok <= tap_in;
    tap_k  <= $signed(coef_all[8*ki +: 8]);
    if (state == pcf_pkg::S_BASE) begin
      acc <= '0;
    end else if (tap_v && tap_ok) begin
      acc <= acc + 24'(prod);
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_fin_beat, clk, rst, state == pcf_pkg::S_FIN && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid, "result beat not loaded")
  `ASSERT_IMPL(a_div_wait, clk, rst, div_out.valid, state == pcf_pkg::S_DIV, "divider result outside wait state")
  `ASSERT_IMPL(a_wr_range, clk, rst, state == pcf_pkg::S_WRITE, rm < LQ, "write address beyond line store")
  `ASSERT_IMPL(a_rd_range, clk, rst, state == pcf_pkg::S_TAP, addr < AW'(L), "tap address beyond line store")

endmodule

[dv/tb_plane_convolution_filter.sv]
`timescale 1ns / 1ps
module tb_plane_convolution_filter;

  localparam int MAX_W    = 2048;
  localparam int HALF     = 2;
  localparam int LS_DEPTH = (2 * HALF + 1) * (MAX_W + 1);
  localparam int HOLDOFF  = 300;
  localparam int LIMIT    = 4000000;

  class conv_scoreboard;
    byte unsigned lines[LS_DEPTH];
    int in_col, in_row, out_col, out_row;
    logic [63:0] grp_a, grp_b, grp_c;
    logic [7:0]  coef_last;
    logic [16:0] div_reg;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    bit          chroma;
    logic [8:0]  pending[$];
    int          mismatches;

    function new();
      grp_a = 0; grp_b = 0; grp_c = 0; coef_last = 0; div_reg = 1;
      width_reg = 720; height_reg = 576; chroma = 0; mismatches = 0;
      clear();
    endfunction

    function void clear();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function bit busy();
      return (in_col | in_row | out_col | out_row) != 0;
    endfunction

    function void set_reg(pcf_pkg::cfg_idx_t idx, logic [63:0] v);
      case (idx)
        pcf_pkg::CFG_COEFF_A:   grp_a = v;
        pcf_pkg::CFG_COEFF_B:   grp_b = v;
        pcf_pkg::CFG_COEFF_C:   grp_c = v;
        pcf_pkg::CFG_COEFF_FIN: coef_last = v[7:0];
        pcf_pkg::CFG_DIVISOR:   div_reg = v[16:0];
        pcf_pkg::CFG_WIDTH:     width_reg = v[11:0];
        pcf_pkg::CFG_HEIGHT:    height_reg = v[12:0];
        pcf_pkg::CFG_CHROMA:    chroma = v[0];
        default: ;
      endcase
    endfunction

    function int coeff(int k);
      logic [7:0] b;
      if (k == 24) b = coef_last;
      else if (k < 8) b = grp_a[8*k +: 8];
      else if (k < 16) b = grp_b[8*(k-8) +: 8];
      else b = grp_c[8*(k-16) +: 8];
      return int'($signed(b));
    endfunction

    // Compute the result, if any, caused by one accepted beat.
    function void note_input(bit op, byte unsigned pix);
      int w, ht, delay, n, o, acc, d, q, r, c, s;
      bit complete;
      w = (width_reg == 0) ? 1 : (width_reg > MAX_W ? MAX_W : int'(width_reg));
      ht = (height_reg == 0) ? 1 : int'(height_reg);
      delay = HALF * w + HALF;
      if (out_row >= ht) clear();
      if (!op && in_row < ht) begin
        lines[(in_row * w + in_col) % LS_DEPTH] = pix;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      complete = in_row >= ht;
      n = complete ? ht * w : in_row * w + in_col;
      o = out_row * w + out_col;
      if (!complete && n < o + delay + 1) return;
      acc = 0;
      for (int dy = -HALF; dy <= HALF; dy++) begin
        for (int dx = -HALF; dx <= HALF; dx++) begin
          r = out_row + dy;
          c = out_col + dx;
          if (r < 0 || r >= ht || c < 0 || c >= w) continue;
          s = lines[(r * w + c) % LS_DEPTH];
          if (chroma) s -= pcf_pkg::CHROMA_OFS;
          acc += s * coeff((dy + 2) * 5 + (dx + 2));
        end
      end
      d = int'($signed(div_reg));
      if (d == 0) d = 1;
      q = acc / d;
      if ((acc % d) != 0 && ((acc < 0) != (d < 0))) q--;
      if (chroma) begin
        if (q < pcf_pkg::CHROMA_MIN) q = pcf_pkg::CHROMA_MIN;
        if (q > pcf_pkg::CHROMA_MAX) q = pcf_pkg::CHROMA_MAX;
        q += pcf_pkg::CHROMA_OFS;
      end else begin
        if (q < pcf_pkg::LUMA_MIN) q = pcf_pkg::LUMA_MIN;
        if (q > pcf_pkg::LUMA_MAX) q = pcf_pkg::LUMA_MAX;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (out_row >= ht) begin
        pending.push_back({1'b1, q[7:0]});
        clear();
      end else begin
        pending.push_back({1'b0, q[7:0]});
      end
    endfunction

    function void check(logic [7:0] pix, logic lst);
      logic [8:0] exp_beat;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: pixel %0d last %0b", pix, lst);
        return;
      end
      exp_beat = pending.pop_front();
      if (exp_beat[7:0] !== pix || exp_beat[8] !== lst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   exp_beat[7:0], exp_beat[8], pix, lst);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [63:0] cfg_data = 0;

  conv_scoreboard sb = new();
  bit  no_gaps = 0;
  int  cycles = 0;
  int  beats_in = 0;

  plane_convolution_filter dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: random stall before each beat, none while no_gaps is set.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      sb.check(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic send_beat(bit op, byte unsigned pix);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pix;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(op, pix);
    beats_in++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task automatic write_reg(pcf_pkg::cfg_idx_t idx, logic [63:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_kernel();
    logic [63:0] a, b, c;
    logic [7:0]  f;
    a = {$urandom, $urandom}; b = {$urandom, $urandom}; c = {$urandom, $urandom};
    f = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      // 3x3 kernel: keep only the center of the grid
      a &= 64'hFFFF_0000_0000_0000;
      b &= 64'h0000_FFFF_FF00_00FF;
      c &= 64'h0000_0000_00FF_FFFF;
      f = 8'h00;
    end
    write_reg(pcf_pkg::CFG_COEFF_A, a);
    write_reg(pcf_pkg::CFG_COEFF_B, b);
    write_reg(pcf_pkg::CFG_COEFF_C, c);
    write_reg(pcf_pkg::CFG_COEFF_FIN, 64'(f));
  endtask

  task automatic random_divisor();
    int d;
    case ($urandom_range(0, 7))
      0: d = 0;
      1: d = 1;
      2: d = -1;
      3: d = 65535;
      4: d = -65535;
      5: d = $urandom_range(1, 64);
      6: d = -$urandom_range(1, 64);
      default: d = $urandom_range(1, 2000);
    endcase
    write_reg(pcf_pkg::CFG_DIVISOR, 64'(d[16:0]));
  endtask

  // Feed one whole plane, with stray flushes when noisy is set, then flush out its tail.
  task automatic run_plane(int w, int h, bit noisy);
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_beat(1, 8'($urandom));
      send_beat(0, rand_pixel());
    end
    while (sb.busy()) send_beat(bit'($urandom_range(0, 1)), 8'($urandom));
  endtask

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: mixed-sign kernel on a 3x3 luma plane
    write_reg(pcf_pkg::CFG_COEFF_A, 64'h0102_0304_05F6_F7F8);
    write_reg(pcf_pkg::CFG_COEFF_B, 64'h7F80_0101_0101_0101);
    write_reg(pcf_pkg::CFG_COEFF_C, 64'h0101_0101_0101_01FF);
    write_reg(pcf_pkg::CFG_COEFF_FIN, 64'h80);
    write_reg(pcf_pkg::CFG_DIVISOR, 64'h0);
    write_reg(pcf_pkg::CFG_WIDTH, 64'd3);
    write_reg(pcf_pkg::CFG_HEIGHT, 64'd3);
    write_reg(pcf_pkg::CFG_CHROMA, 64'd0);
    send_beat(1, 8'hFF);
    send_beat(0, 8'd0);
    send_beat(0, 8'd255);
    send_beat(1, 8'h00);
    for (int i = 0; i < 7; i++) send_beat(0, (i % 2) ? 8'd255 : 8'd0);
    send_beat(0, 8'hAA);
    while (sb.busy()) send_beat(1, 8'h55);
    wait_drained();

    // Chroma, negative divisor, zero width and height
    write_reg(pcf_pkg::CFG_CHROMA, 64'd1);
    write_reg(pcf_pkg::CFG_DIVISOR, 64'h1FFFD);
    write_reg(pcf_pkg::CFG_WIDTH, 64'd0);
    write_reg(pcf_pkg::CFG_HEIGHT, 64'd0);
    run_plane(1, 1, 0);
    wait_drained();

    // Tall plane cut short by a height change
    write_reg(pcf_pkg::CFG_WIDTH, 64'd3);
    write_reg(pcf_pkg::CFG_HEIGHT, 64'd8191);
    for (int i = 0; i < 14; i++) send_beat(0, rand_pixel());
    wait_drained();
    write_reg(pcf_pkg::CFG_HEIGHT, 64'd1);

    // Widest row: width above the maximum, one row, then narrow it to end the plane
    write_reg(pcf_pkg::CFG_CHROMA, 64'd0);
    write_reg(pcf_pkg::CFG_DIVISOR, 64'd65535);
    write_reg(pcf_pkg::CFG_WIDTH, 64'd4095);
    for (int i = 0; i < MAX_W; i++) send_beat(0, rand_pixel());
    wait_drained();
    write_reg(pcf_pkg::CFG_WIDTH, 64'd2);
    while (sb.busy()) send_beat(1, 8'h00);
    wait_drained();

    while (beats_in < 2300) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      random_kernel();
      random_divisor();
      write_reg(pcf_pkg::CFG_CHROMA, 64'($urandom_range(0, 1)));
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      write_reg(pcf_pkg::CFG_WIDTH, 64'(w));
      write_reg(pcf_pkg::CFG_HEIGHT, 64'(h));
      repeat ($urandom_range(1, 3)) run_plane(w, h, 1);
      wait_drained();
    end
    no_gaps = 0;

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pcf_pkg.sv
rtl/pcf_div_cell.sv
rtl/pcf_div_chain.sv
rtl/plane_convolution_filter.sv
dv/tb_plane_convolution_filter.sv
